### hdl/tcls_pkg.sv
// Shared types, codes and constants for the timed cue list sequencer.
// No dependencies; used by tcls_ram users and the sequencer core.
package tcls_pkg;

   localparam int TABLE_DEPTH_DEF = 64;

   // Largest start time or length accepted, 1e6 in Q20.12.
   localparam logic [31:0] LIMIT_Q = 32'd4096000000;

   localparam logic [8:0] NUM_TARGETS_RST = 9'd256;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic KIND_CMD    = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [2:0] STAT_OK         = 3'd0;
   localparam logic [2:0] STAT_START_BIG  = 3'd1;
   localparam logic [2:0] STAT_LENGTH_BIG = 3'd2;
   localparam logic [2:0] STAT_BAD_TARGET = 3'd3;
   localparam logic [2:0] STAT_FULL       = 3'd4;

   typedef enum logic {
      S_IDLE,
      S_WALK
   } state_type;

   typedef struct packed {
      logic [31:0] start;
      logic [31:0] length;
      logic [7:0]  target;
   } cue_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  target;
      logic [31:0] time_into;
      logic [31:0] length;
      logic [2:0]  status;
   } result_type;

endpackage

### hdl/timed_cue_list_sequencer_core.sv
// Timed cue list sequencer: cue table in RAM, load/tick/clear handling.
// Depends on tcls_pkg and tcls_ram.
//
// Usage: one request channel (req_*) with valid/stall and one response
// channel (rsp_*) with valid/stall. A request is one beat carrying an
// opcode and the load or tick fields. A load or clear returns one status
// beat, presented the cycle after it is accepted. A tick walks the cue
// table from the resume pointer, one entry per cycle out of the cue RAM
// while the receiver does not stall, and returns zero or more command
// beats; rsp_last marks the final beat of a request. A tick occupies the
// block until its walk ends, after visiting at most TABLE_DEPTH entries,
// which are read one at a time through the single read port of the cue RAM.
// Loads and clears do not leave the idle state. Requests are taken only while no
// tick is in progress and the response register is free or draining.
// If the receiver stalls, the walk pauses on the entry that wants to emit
// and resumes when the response register drains; no beat is lost.
// Reset empties the table, zeroes the resume pointer and sets num_targets
// to 256. The RAM contents are not cleared; only written entries are used.
// csr_wr_en writes num_targets; write it only while the block is idle.
module timed_cue_list_sequencer_core #(
   parameter int TABLE_DEPTH = tcls_pkg::TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_tick_time,
   input  logic [31:0] req_start_time,
   input  logic [31:0] req_run_length,
   input  logic [7:0]  req_target_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_cmd_target,
   output logic [31:0] rsp_time_into,
   output logic [31:0] rsp_cmd_length,
   output logic [2:0]  rsp_status,
   output logic        rsp_last
);

   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CUE_W  = $bits(tcls_pkg::cue_type);

   tcls_pkg::state_type  state_ff, state_in;
   logic [8:0]           num_targets_ff, num_targets_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     resume_ff, resume_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [31:0]          tick_ff, tick_in;
   tcls_pkg::result_type pend_ff, pend_in;
   logic                 pend_valid_ff, pend_valid_in;
   tcls_pkg::result_type out_ff, out_in;
   logic                 out_last_ff, out_last_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 out_free;
   logic                 req_accept;
   logic [2:0]           load_status;

   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_rd_addr;
   logic [CUE_W-1:0]     ram_rd_data;
   tcls_pkg::cue_type    cue;
   tcls_pkg::cue_type    new_cue;

   logic                 at_end;
   logic                 is_zero;
   logic                 expired;
   logic                 future;
   logic                 emit;
   logic                 skip;
   logic                 done;
   logic                 emit_blocked;
   logic                 step_go;
   logic                 done_go;
   logic [32:0]          end_sum;
   tcls_pkg::result_type cmd;

   assign new_cue = '{start: req_start_time, length: req_run_length, target: req_target_index};

   // The table is only written while idle and its read data is only used during a
   // walk, so a used read never overlaps a write to the same entry.
   tcls_ram #(
      .WIDTH (CUE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_cue_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (new_cue),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign cue = tcls_pkg::cue_type'(ram_rd_data);

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == tcls_pkg::S_IDLE) && out_free);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_start_time > tcls_pkg::LIMIT_Q) begin
         load_status = tcls_pkg::STAT_START_BIG;
      end else if (req_run_length > tcls_pkg::LIMIT_Q) begin
         load_status = tcls_pkg::STAT_LENGTH_BIG;
      end else if ({1'b0, req_target_index} >= num_targets_ff) begin
         load_status = tcls_pkg::STAT_BAD_TARGET;
      end else if (count_ff == CNT_W'(TABLE_DEPTH)) begin
         load_status = tcls_pkg::STAT_FULL;
      end else begin
         load_status = tcls_pkg::STAT_OK;
      end
   end

   // Classification of the entry whose read data is present this cycle.
   always_comb begin
      end_sum  = {1'b0, cue.start} + {1'b0, cue.length};
      at_end   = (idx_ff == count_ff);
      is_zero  = (cue.length == 32'd0);
      expired  = (end_sum < {1'b0, tick_ff});
      future   = (tick_ff < cue.start);
      emit     = !at_end && (is_zero || (!expired && !future));
      skip     = !at_end && !is_zero && expired;
      done     = at_end || (!is_zero && !expired && future);
      emit_blocked = emit && pend_valid_ff && !out_free;
      step_go  = (state_ff == tcls_pkg::S_WALK) && (emit || skip) && !emit_blocked;
      done_go  = (state_ff == tcls_pkg::S_WALK) && done && !(pend_valid_ff && !out_free);
      cmd.kind      = tcls_pkg::KIND_CMD;
      cmd.target    = cue.target;
      cmd.time_into = is_zero ? 32'd0 : (tick_ff - cue.start);
      cmd.length    = cue.length;
      cmd.status    = tcls_pkg::STAT_OK;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcls_pkg::S_IDLE: begin
            if (req_accept && (req_opcode == tcls_pkg::OP_TICK)) begin
               state_in = tcls_pkg::S_WALK;
            end
         end
         tcls_pkg::S_WALK: begin
            if (done_go) begin
               state_in = tcls_pkg::S_IDLE;
            end
         end
         default: state_in = tcls_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      num_targets_in = csr_wr_en ? csr_wr_data : num_targets_ff;
      count_in       = count_ff;
      resume_in      = resume_ff;
      idx_in         = idx_ff;
      tick_in        = tick_ff;
      pend_in        = pend_ff;
      pend_valid_in  = pend_valid_ff;
      out_in         = out_ff;
      out_last_in    = out_last_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      ram_wr_en      = 1'b0;
      ram_rd_addr    = resume_ff[ADDR_W-1:0];

      case (state_ff)
         tcls_pkg::S_IDLE: begin
            if (req_accept) begin
               case (req_opcode)
                  tcls_pkg::OP_LOAD: begin
                     if (load_status == tcls_pkg::STAT_OK) begin
                        ram_wr_en = 1'b1;
                        count_in  = count_ff + CNT_W'(1);
                     end
                     out_in       = '{kind: tcls_pkg::KIND_STATUS, target: 8'd0,
                                      time_into: 32'd0, length: 32'd0,
                                      status: load_status};
                     out_last_in  = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  tcls_pkg::OP_TICK: begin
                     idx_in  = resume_ff;
                     tick_in = req_tick_time;
                  end
                  tcls_pkg::OP_CLEAR: begin
                     count_in     = '0;
                     resume_in    = '0;
                     out_in       = '{kind: tcls_pkg::KIND_STATUS, target: 8'd0,
                                      time_into: 32'd0, length: 32'd0,
                                      status: tcls_pkg::STAT_OK};
                     out_last_in  = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         tcls_pkg::S_WALK: begin
            // Read the next entry when stepping, otherwise re-read this one.
            ram_rd_addr = step_go ? (idx_ff[ADDR_W-1:0] + ADDR_W'(1))
                                  : idx_ff[ADDR_W-1:0];
            if (step_go) begin
               idx_in = idx_ff + CNT_W'(1);
               if (is_zero || skip) begin
                  resume_in = resume_ff + CNT_W'(1);
               end
               if (emit) begin
                  // The held command is not the final one, since another follows.
                  if (pend_valid_ff) begin
                     out_in       = pend_ff;
                     out_last_in  = 1'b0;
                     rsp_valid_in = 1'b1;
                  end
                  pend_in       = cmd;
                  pend_valid_in = 1'b1;
               end
            end else if (done_go && pend_valid_ff) begin
               out_in        = pend_ff;
               out_last_in   = 1'b1;
               rsp_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tcls_pkg::S_IDLE;
         num_targets_ff <= tcls_pkg::NUM_TARGETS_RST;
         count_ff       <= '0;
         resume_ff      <= '0;
         idx_ff         <= '0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         num_targets_ff <= num_targets_in;
         count_ff       <= count_in;
         resume_ff      <= resume_in;
         idx_ff         <= idx_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tick_ff     <= tick_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = out_ff.kind;
   assign rsp_cmd_target = out_ff.target;
   assign rsp_time_into  = out_ff.time_into;
   assign rsp_cmd_length = out_ff.length;
   assign rsp_status     = out_ff.status;
   assign rsp_last       = out_last_ff;

`ifndef ASSERT_OFF
   // The resume pointer never passes the fill level of the table.
   a_resume_in_table: assert property (@(posedge clock) disable iff (reset)
      resume_ff <= count_ff)
      else $error("resume pointer beyond table fill");

   // A walk never looks past the last loaded entry.
   a_walk_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcls_pkg::S_WALK) |-> (idx_ff <= count_ff))
      else $error("walk index beyond table fill");

   // Every held command is flushed before the block goes idle.
   a_no_pending_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcls_pkg::S_IDLE) |-> !pend_valid_ff)
      else $error("command left pending while idle");

   // A finished walk leaves its final beat marked as last.
   a_walk_end_last: assert property (@(posedge clock) disable iff (reset)
      (done_go && pend_valid_ff) |=> (rsp_valid_ff && out_last_ff))
      else $error("final walk beat not marked last");
`endif

endmodule

### hdl/tcls_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module tcls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for timed_cue_list_sequencer_core: loads, ticks and clears are
// driven with random idling and predicted here. Depends on tcls_pkg and the core RTL.
module tb;

   localparam int DEPTH = tcls_pkg::TABLE_DEPTH_DEF;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic        kind;
      logic [7:0]  target;
      logic [31:0] time_into;
      logic [31:0] length;
      logic [2:0]  status;
      logic        last;
   } beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [8:0]  csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = '0;
   logic [31:0] req_tick_time = '0;
   logic [31:0] req_start_time = '0;
   logic [31:0] req_run_length = '0;
   logic [7:0]  req_target_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_cmd_target;
   logic [31:0] rsp_time_into;
   logic [31:0] rsp_cmd_length;
   logic [2:0]  rsp_status;
   logic        rsp_last;

   // Predicted cue table and walk pointer.
   logic [31:0] cue_at [DEPTH];
   logic [31:0] cue_len [DEPTH];
   logic [7:0]  cue_dest [DEPTH];
   int          cue_count = 0;
   int          walk_ptr = 0;
   logic [8:0]  target_limit = tcls_pkg::NUM_TARGETS_RST;

   beat_type expected_beats[$];
   int    err_count = 0;
   int    cycle_count = 0;
   logic  idle_on = 1'b0;
   logic  holding = 1'b0;
   int    stall_left = 0;
   event  hold_go;

   timed_cue_list_sequencer_core DUT (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_tick_time(req_tick_time),
      .req_start_time(req_start_time),
      .req_run_length(req_run_length),
      .req_target_index(req_target_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_cmd_target(rsp_cmd_target),
      .rsp_time_into(rsp_time_into),
      .rsp_cmd_length(rsp_cmd_length),
      .rsp_status(rsp_status),
      .rsp_last(rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // Receiver idling: short random bursts, plus the long hold-off when requested.
   always @(posedge clock) begin
      if (stall_left > 0)
         stall_left = stall_left - 1;
      else if (idle_on && $urandom_range(0, 4) == 0)
         stall_left = $urandom_range(1, 6);
      rsp_stall <= holding || (stall_left > 0);
   end

   initial begin : receiver_hold
      forever begin
         @(hold_go);
         @(posedge clock);
         holding <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         holding <= 1'b0;
      end
   end

   function automatic void apply_request(input logic [1:0] op, input logic [31:0] tick,
                                         input logic [31:0] st, input logic [31:0] ln,
                                         input logic [7:0] tg);
      beat_type outs[$];
      beat_type b;
      logic [2:0] code;
      b = '0;
      case (op)
         tcls_pkg::OP_LOAD: begin
            code = tcls_pkg::STAT_OK;
            if (st > tcls_pkg::LIMIT_Q)
               code = tcls_pkg::STAT_START_BIG;
            else if (ln > tcls_pkg::LIMIT_Q)
               code = tcls_pkg::STAT_LENGTH_BIG;
            else if ({1'b0, tg} >= target_limit)
               code = tcls_pkg::STAT_BAD_TARGET;
            else if (cue_count >= DEPTH)
               code = tcls_pkg::STAT_FULL;
            if (code == tcls_pkg::STAT_OK) begin
               cue_at[cue_count] = st;
               cue_len[cue_count] = ln;
               cue_dest[cue_count] = tg;
               cue_count++;
            end
            b.kind = tcls_pkg::KIND_STATUS;
            b.status = code;
            outs.push_back(b);
         end
         tcls_pkg::OP_TICK: begin
            // The pointer only counts skipped and zero-length cues, so it can fall behind an active one.
            for (int i = walk_ptr; i < cue_count; i++) begin
               if (cue_len[i] == 0) begin
                  b = '0;
                  b.kind = tcls_pkg::KIND_CMD;
                  b.target = cue_dest[i];
                  outs.push_back(b);
                  walk_ptr++;
               end else if ({1'b0, cue_at[i]} + {1'b0, cue_len[i]} < {1'b0, tick}) begin
                  walk_ptr++;
               end else if (tick < cue_at[i]) begin
                  break;
               end else begin
                  b = '0;
                  b.kind = tcls_pkg::KIND_CMD;
                  b.target = cue_dest[i];
                  b.time_into = tick - cue_at[i];
                  b.length = cue_len[i];
                  outs.push_back(b);
               end
            end
         end
         tcls_pkg::OP_CLEAR: begin
            cue_count = 0;
            walk_ptr = 0;
            b.kind = tcls_pkg::KIND_STATUS;
            b.status = tcls_pkg::STAT_OK;
            outs.push_back(b);
         end
         default: ;
      endcase
      if (outs.size() > 0) begin
         b = outs.pop_back();
         b.last = 1'b1;
         outs.push_back(b);
      end
      foreach (outs[k])
         expected_beats.push_back(outs[k]);
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         err_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : check_beats
      beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            err_count++;
            $display("%0t: beat with none expected, expected nothing, actual kind %0d target %0h",
                     $time, rsp_kind, rsp_cmd_target);
         end else begin
            want = expected_beats.pop_front();
            check_field("kind", 32'(want.kind), 32'(rsp_kind));
            check_field("cmd_target", 32'(want.target), 32'(rsp_cmd_target));
            check_field("time_into", want.time_into, rsp_time_into);
            check_field("cmd_length", want.length, rsp_cmd_length);
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("last", 32'(want.last), 32'(rsp_last));
         end
      end
   end

   task automatic send_request(input logic [1:0] op, input logic [31:0] tick,
                               input logic [31:0] st, input logic [31:0] ln,
                               input logic [7:0] tg);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_tick_time <= tick;
      req_start_time <= st;
      req_run_length <= ln;
      req_target_index <= tg;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_request(op, tick, st, ln, tg);
   endtask

   task automatic send_load(input logic [31:0] st, input logic [31:0] ln,
                            input logic [7:0] tg);
      send_request(tcls_pkg::OP_LOAD, $urandom, st, ln, tg);
   endtask

   task automatic send_tick(input logic [31:0] tick);
      send_request(tcls_pkg::OP_TICK, tick, $urandom, $urandom, 8'($urandom));
   endtask

   task automatic send_clear();
      send_request(tcls_pkg::OP_CLEAR, $urandom, $urandom, $urandom, 8'($urandom));
   endtask

   // A tick that emits nothing may still be walking, so allow a full walk after the last beat.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_target_limit(input logic [8:0] value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      target_limit = value;
   endtask

   function automatic logic [7:0] pick_target();
      if (target_limit == 0 || target_limit > 256 || $urandom_range(0, 9) == 0)
         return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, target_limit - 1));
   endfunction

   task automatic test_load_checks();
      send_load(tcls_pkg::LIMIT_Q, tcls_pkg::LIMIT_Q, 8'hFF);
      send_load(tcls_pkg::LIMIT_Q + 1, 32'hFFFF_FFFF, 8'h00);
      send_load(32'h0, tcls_pkg::LIMIT_Q + 1, 8'h00);
      send_load(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
      send_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
      send_clear();
   endtask

   task automatic test_walk_cases();
      send_load(32'h0, 32'h0, 8'h00);
      send_load(32'h10, 32'h100, 8'hAA);
      send_load(32'h20, 32'h4, 8'h55);
      send_load(32'h5000, 32'h10, 8'h01);
      send_load(tcls_pkg::LIMIT_Q, tcls_pkg::LIMIT_Q, 8'hFF);
      // Zero-length, active, then expired cue; the future cue ends the walk.
      send_tick(32'h30);
      // The active cue now lies behind the pointer and is not visited again.
      send_tick(32'h40);
      send_tick(32'h5008);
      // The last cue ends past 32 bits, so it must not count as expired.
      send_tick(32'hFFFF_FFFF);
      send_clear();
      send_tick(32'h0);
   endtask

   task automatic test_target_limit();
      write_target_limit(9'd0);
      send_load(32'h100, 32'h10, 8'h00);
      send_load(tcls_pkg::LIMIT_Q + 1, 32'h10, 8'h00);
      write_target_limit(9'd1);
      send_load(32'h100, 32'h10, 8'h00);
      send_load(32'h100, 32'h10, 8'h01);
      write_target_limit(9'd384);
      send_load(32'h200, 32'h10, 8'hFF);
      send_clear();
   endtask

   task automatic test_cue_rounds(input int rounds);
      logic [31:0] base;
      logic [31:0] at;
      logic [31:0] t;
      repeat (rounds) begin
         case ($urandom_range(0, 5))
            0: write_target_limit(9'd1);
            1: write_target_limit(9'd17);
            2: write_target_limit(9'd255);
            3: write_target_limit(9'd256);
            default: write_target_limit(9'($urandom_range(0, 256)));
         endcase
         if ($urandom_range(0, 3) != 0)
            send_clear();
         if ($urandom_range(0, 3) == 0)
            base = $urandom_range(tcls_pkg::LIMIT_Q - 32'h4000, tcls_pkg::LIMIT_Q);
         else
            base = $urandom_range(0, 32'h10_0000);
         at = base;
         repeat ($urandom_range(1, 10)) begin
            at = at + $urandom_range(0, 32'h300);
            case ($urandom_range(0, 11))
               0: send_load($urandom_range(tcls_pkg::LIMIT_Q + 1, 32'hFFFF_FFFF), $urandom,
                            pick_target());
               1: send_load(at, $urandom_range(tcls_pkg::LIMIT_Q + 1, 32'hFFFF_FFFF),
                            pick_target());
               2: send_request(OP_UNUSED, $urandom, $urandom, $urandom, 8'($urandom));
               3, 4: send_load(at, 32'h0, pick_target());
               default: send_load(at, $urandom_range(1, 32'h800), pick_target());
            endcase
         end
         t = base;
         repeat ($urandom_range(2, 6)) begin
            t = t + $urandom_range(0, 32'h400);
            if ($urandom_range(0, 9) == 0)
               send_tick($urandom);
            else
               send_tick(t);
         end
      end
   endtask

   task automatic test_receiver_hold();
      wait_idle();
      send_clear();
      -> hold_go;
      repeat (8)
         send_load($urandom_range(0, 32'h80), $urandom_range(32'h400, 32'h800), pick_target());
      repeat (10)
         send_tick($urandom_range(32'h80, 32'h300));
   endtask

   task automatic test_full_table();
      write_target_limit(9'd255);
      send_clear();
      // Every start lies below the first tick, so one tick can emit for the whole table.
      repeat (66) begin
         if ($urandom_range(0, 7) == 0)
            send_load($urandom_range(0, 32'h100), 32'h0, pick_target());
         else
            send_load($urandom_range(0, 32'h100), $urandom_range(32'h800, 32'h1000),
                      pick_target());
      end
      send_tick(32'h180);
      send_tick(32'h200);
      send_tick(32'h2000);
      send_tick(32'h2100);
      send_load(32'h10, 32'h10, 8'h00);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      idle_on <= 1'b1;
      test_load_checks();
      test_walk_cases();
      test_target_limit();
      test_cue_rounds(3);
      test_receiver_hold();
      test_full_table();
      wait_idle();
      idle_on <= 1'b0;
      test_cue_rounds(2);
      wait_idle();
      if (err_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
